[design/mmp_pkg.sv]
// mmp_pkg: shared types, codes and a fixed-point helper for the marginal propagation block
// no dependencies; used by every module of the block
`default_nettype none

package mmp_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [PROB_W-1:0] Q_ONE = 16'h8000;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_TRANS = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_STATE_COUNT   = 1'b0,
    CFG_NUM_POSITIONS = 1'b1
  } cfg_index_t;

  // request from the update stage to the result buffer
  typedef struct packed {
    logic               load;
    logic [STATE_W-1:0] first;
    logic [STATE_W-1:0] stop;
    logic [STATE_W-1:0] top;
    logic [POS_W-1:0]   position;
    logic               series;
  } emit_t;

  // clamp a sum or a raw probability to 1.0
  function automatic logic [PROB_W-1:0] sat_q(input logic [PROB_W:0] v);
    return (v > {1'b0, Q_ONE}) ? Q_ONE : v[PROB_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/mmp_core.sv]
// mmp_core: input register and single-pass marginal update (multiply, accumulate, close)
// depends on mmp_pkg
`default_nettype none

module mmp_core #(
  parameter int unsigned MAX_STATES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic [mmp_pkg::COUNT_W-1:0]   state_count,
  input  wire logic [mmp_pkg::POS_W-1:0]     num_positions,
  input  wire logic                          out_free,
  output mmp_pkg::emit_t                     emit,
  output logic [mmp_pkg::PROB_W-1:0]         emit_vec [(MAX_STATES < 8 ? MAX_STATES : 8)]
);

  localparam int unsigned NS = (MAX_STATES < 8) ? MAX_STATES : 8;
  localparam logic [mmp_pkg::COUNT_W-1:0] LIM = mmp_pkg::COUNT_W'(NS);
  localparam logic [mmp_pkg::COUNT_W-1:0] MIN_N = 4'd2;

  logic                          item_valid_r;
  mmp_pkg::opcode_t              op_r;
  logic [mmp_pkg::STATE_W-1:0]   from_r, to_r;
  logic [mmp_pkg::PROB_W-1:0]    prob_r;
  logic [mmp_pkg::PROB_W-1:0]    prev_r [NS];
  logic [mmp_pkg::PROB_W-1:0]    acc_r  [NS];
  logic [mmp_pkg::POS_W-1:0]     pos_r;

  logic [mmp_pkg::COUNT_W-1:0]   n;
  logic [mmp_pkg::STATE_W-1:0]   nm1;
  logic [mmp_pkg::POS_W-1:0]     final_pos;
  logic [mmp_pkg::PROB_W-1:0]    p;
  logic [mmp_pkg::PROB_W-1:0]    prev_sel, acc_sel, prod, acc_new_to;
  logic [31:0]                   prod_full;
  logic                          from_ok, to_ok, begin_ok, trans_ok, close, needs_out;
  logic                          advance;
  logic [mmp_pkg::POS_W-1:0]     pos_inc;
  logic [mmp_pkg::PROB_W-1:0]    prev_new [NS];
  logic [mmp_pkg::PROB_W-1:0]    acc_new  [NS];

  // active state count clamped to at least 2 and at most the storage
  always_comb begin
    if (state_count < MIN_N) begin
      n = MIN_N;
    end else if (state_count > LIM) begin
      n = LIM;
    end else begin
      n = state_count;
    end
  end

  assign nm1       = mmp_pkg::STATE_W'(n - 4'd1);
  assign final_pos = (num_positions == '0) ? '0 : num_positions - 16'd1;
  assign p         = mmp_pkg::sat_q({1'b0, prob_r});
  assign from_ok   = {1'b0, from_r} < n;
  assign to_ok     = {1'b0, to_r} < n;
  assign begin_ok  = (op_r == mmp_pkg::OP_BEGIN) && to_ok;
  assign trans_ok  = (op_r == mmp_pkg::OP_TRANS) && from_ok && to_ok;
  assign close     = trans_ok && (from_r == nm1) && (to_r == nm1);
  assign needs_out = begin_ok || close;
  assign advance   = item_valid_r && (!needs_out || out_free);
  assign in_tready = !item_valid_r || advance;
  assign pos_inc   = pos_r + 16'd1;

  always_comb begin
    prev_sel = '0;
    acc_sel  = '0;
    for (int j = 0; j < NS; j++) begin
      if (from_r == mmp_pkg::STATE_W'(j)) begin
        prev_sel = prev_r[j];
      end
      if (to_r == mmp_pkg::STATE_W'(j)) begin
        acc_sel = acc_r[j];
      end
    end
  end

  // product fits 16 bits since both operands are at most 1.0
  assign prod_full  = prev_sel * p;
  assign prod       = prod_full[30:15];
  assign acc_new_to = mmp_pkg::sat_q({1'b0, acc_sel} + {1'b0, prod});

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      prev_new[j] = (to_r == mmp_pkg::STATE_W'(j)) ? p : prev_r[j];
      acc_new[j]  = (to_r == mmp_pkg::STATE_W'(j)) ? acc_new_to : acc_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      pos_r        <= '0;
      for (int j = 0; j < NS; j++) begin
        prev_r[j] <= '0;
        acc_r[j]  <= '0;
      end
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (advance) begin
        if (begin_ok) begin
          pos_r <= '0;
          for (int j = 0; j < NS; j++) begin
            prev_r[j] <= prev_new[j];
            acc_r[j]  <= '0;
          end
        end else if (close) begin
          pos_r <= pos_inc;
          for (int j = 0; j < NS; j++) begin
            prev_r[j] <= acc_new[j];
            acc_r[j]  <= '0;
          end
        end else if (trans_ok) begin
          for (int j = 0; j < NS; j++) begin
            acc_r[j] <= acc_new[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= mmp_pkg::opcode_t'(in_tuser);
      from_r <= in_tdata[2:0];
      to_r   <= in_tdata[5:3];
      prob_r <= in_tdata[21:6];
    end
  end

  always_comb begin
    emit.load     = advance && needs_out;
    emit.first    = begin_ok ? to_r : '0;
    emit.stop     = begin_ok ? to_r : nm1;
    emit.top      = nm1;
    emit.position = begin_ok ? '0 : pos_inc;
    emit.series   = begin_ok ? (final_pos == '0) : (pos_inc == final_pos);
    for (int j = 0; j < NS; j++) begin
      emit_vec[j] = begin_ok ? prev_new[j] : acc_new[j];
    end
  end

endmodule

`default_nettype wire

[design/mmp_outbuf.sv]
// mmp_outbuf: result buffer holding one marginal vector, drained a word per ready cycle
// depends on mmp_pkg
`default_nettype none

module mmp_outbuf #(
  parameter int unsigned MAX_STATES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mmp_pkg::emit_t            emit,
  input  wire logic [mmp_pkg::PROB_W-1:0] emit_vec [(MAX_STATES < 8 ? MAX_STATES : 8)],
  output logic                           out_free,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [39:0]                    out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);

  localparam int unsigned NS = (MAX_STATES < 8) ? MAX_STATES : 8;

  logic                         busy_r;
  logic [mmp_pkg::STATE_W-1:0]  idx_r, stop_r, top_r;
  logic [mmp_pkg::POS_W-1:0]    pos_r;
  logic                         series_r;
  logic [mmp_pkg::PROB_W-1:0]   data_r [NS];
  logic [mmp_pkg::PROB_W-1:0]   data_sel;
  logic                         at_stop;

  assign at_stop  = idx_r == stop_r;
  assign out_free = !busy_r || (out_tready && at_stop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (emit.load) begin
      busy_r <= 1'b1;
    end else if (busy_r && out_tready && at_stop) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      idx_r    <= emit.first;
      stop_r   <= emit.stop;
      top_r    <= emit.top;
      pos_r    <= emit.position;
      series_r <= emit.series;
      for (int j = 0; j < NS; j++) begin
        data_r[j] <= emit_vec[j];
      end
    end else if (busy_r && out_tready && !at_stop) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_comb begin
    data_sel = '0;
    for (int j = 0; j < NS; j++) begin
      if (idx_r == mmp_pkg::STATE_W'(j)) begin
        data_sel = data_r[j];
      end
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {5'd0, data_sel, idx_r, pos_r};
  assign out_tlast  = idx_r == top_r;
  assign out_tuser  = out_tlast && series_r;

endmodule

`default_nettype wire

[design/markov_marginal_propagation.sv]
// channel | direction | tdata (low bit up)                                | tlast       | tuser
// in      | slave     | from_state[2:0] to_state[5:3] prob[21:6], pad 0  | -           | opcode
// out     | master    | position[15:0] state_index[18:16]                 | last_of_run | series_done
//         |           | marginal_prob[34:19], pad 0                       |             |
// cfg     | write     | index 0 state count, index 1 num_positions        | -           | -
//
// an input word is taken every cycle unless stalled; it is held in the input register, updated
// in the multiply-accumulate stage, and its results are loaded into the output buffer then
// a begin entry gives one result, a closing element (last,last) gives one per active state,
// drained a word per ready cycle; the input stalls only while a new vector waits on a full buffer
// synchronous active-low reset clears marginals, accumulators and position count
// top level: config registers, update stage and result buffer; depends on mmp_pkg, mmp_core,
// mmp_outbuf
`default_nettype none

module markov_marginal_propagation #(
  parameter int unsigned MAX_STATES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [23:0]                in_tdata,   // from_state, to_state, prob
  input  wire logic                       in_tuser,   // opcode
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [39:0]                     out_tdata,  // position, state_index, marginal_prob
  output logic                            out_tlast,
  output logic                            out_tuser,  // series_done
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [mmp_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int unsigned NS = (MAX_STATES < 8) ? MAX_STATES : 8;

  logic [mmp_pkg::COUNT_W-1:0] state_count_r;
  logic [mmp_pkg::POS_W-1:0]   num_positions_r;
  mmp_pkg::emit_t              emit;
  logic [mmp_pkg::PROB_W-1:0]  emit_vec [NS];
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r   <= 4'd2;
      num_positions_r <= 16'd1;
    end else if (cfg_we) begin
      case (mmp_pkg::cfg_index_t'(cfg_index))
        mmp_pkg::CFG_STATE_COUNT:   state_count_r   <= cfg_wdata[mmp_pkg::COUNT_W-1:0];
        mmp_pkg::CFG_NUM_POSITIONS: num_positions_r <= cfg_wdata[mmp_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  mmp_core #(
    .MAX_STATES(MAX_STATES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .state_count  (state_count_r),
    .num_positions(num_positions_r),
    .out_free     (out_free),
    .emit         (emit),
    .emit_vec     (emit_vec)
  );

  mmp_outbuf #(
    .MAX_STATES(MAX_STATES)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .emit_vec  (emit_vec),
    .out_free  (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[design/mmp_checker.sv]
// mmp_checker: port-level checks on the result stream, bound to the top level
// depends on mmp_pkg and markov_marginal_propagation
`default_nettype none

module mmp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // end of series only on the closing word of a vector
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("series_done without last_of_run");

  // marginals never exceed one
  a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:19] <= mmp_pkg::Q_ONE)
    else $error("marginal above one");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind markov_marginal_propagation mmp_checker u_mmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

`default_nettype wire
